>>> design/dpb_pkg.sv
package dpb_pkg;

	localparam int DEPTH_W   = 16;
	localparam int COLOR_W   = 8;
	localparam int SIZE_W    = 13;
	localparam int POS_W     = 12;
	localparam int CENTER_W  = 16;
	localparam int INV_W     = 24;
	localparam int Z_W       = 18;
	localparam int COORD_W   = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 24;

	// Largest frame size in either direction.
	localparam logic [SIZE_W-1:0] MAX_WIDTH  = SIZE_W'(4096);
	localparam logic [SIZE_W-1:0] MAX_HEIGHT = SIZE_W'(4096);

	// Depth is divided by this to give z in Q.8.
	localparam int DEPTH_DIVISOR = 100;
	// Scaled numerator: depth * 256 plus half the divisor for rounding.
	localparam int NUM_W = DEPTH_W + 8;
	// floor(2^31 / 100); the quotient estimate is at most one short.
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_W     = 25;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((64'd1 << RECIP_SHIFT) / DEPTH_DIVISOR);

	// Shared multiplier operand and product widths.
	localparam int MUL_A_W = CENTER_W + Z_W;
	localparam int MUL_B_W = RECIP_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// Q.36 to Q.8 shift.
	localparam int FRAC_SHIFT = 28;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = CFG_IDX_W'(5);

	typedef struct packed {
		logic [SIZE_W-1:0]   frame_width;
		logic [SIZE_W-1:0]   frame_height;
		logic [CENTER_W-1:0] center_x;
		logic [CENTER_W-1:0] center_y;
		logic [INV_W-1:0]    inv_focal_x;
		logic [INV_W-1:0]    inv_focal_y;
	} dpb_cfg_t;

	typedef enum logic [2:0] {
		MUL_Z,
		MUL_MAGX,
		MUL_MAGY,
		MUL_INVX,
		MUL_INVY
	} dpb_mul_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ZMUL,
		ST_ZFIX,
		ST_XMAG,
		ST_XINV,
		ST_XRND,
		ST_YINV,
		ST_YRND,
		ST_DONE
	} dpb_state_t;

	typedef struct packed {
		logic         capture;
		logic         mul_en;
		dpb_mul_sel_t mul_sel;
		logic         z_load;
		logic         x_load;
		logic         y_load;
		logic         out_load;
	} dpb_cmd_t;

	typedef struct packed {
		logic depth_zero;
		logic last_pixel;
		logic out_free;
	} dpb_status_t;

endpackage

>>> design/dpb_ctrl.sv
module dpb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dpb_pkg::dpb_status_t status,
	output dpb_pkg::dpb_cmd_t    cmd
);
	import dpb_pkg::*;

	dpb_state_t state_q;
	dpb_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next  = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.mul_sel = MUL_Z;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (!status.depth_zero) begin
						state_next = ST_ZMUL;
					end else if (status.last_pixel) begin
						state_next = ST_DONE;
					end
				end
			end
			ST_ZMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Z;
				state_next  = ST_ZFIX;
			end
			ST_ZFIX: begin
				cmd.z_load = 1'b1;
				state_next = ST_XMAG;
			end
			ST_XMAG: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MAGX;
				state_next  = ST_XINV;
			end
			ST_XINV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INVX;
				state_next  = ST_XRND;
			end
			ST_XRND: begin
				cmd.x_load  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MAGY;
				state_next  = ST_YINV;
			end
			ST_YINV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INVY;
				state_next  = ST_YRND;
			end
			ST_YRND: begin
				cmd.y_load = 1'b1;
				state_next = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/dpb_datapath.sv
module dpb_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpb_pkg::dpb_cfg_t             cfg,
	input  dpb_pkg::dpb_cmd_t             cmd,
	output dpb_pkg::dpb_status_t          status,
	input  logic [dpb_pkg::DEPTH_W-1:0]   depth_value,
	input  logic [dpb_pkg::COLOR_W-1:0]   blue,
	input  logic [dpb_pkg::COLOR_W-1:0]   green,
	input  logic [dpb_pkg::COLOR_W-1:0]   red,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [dpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dpb_pkg::COORD_W-1:0] point_y,
	output logic [dpb_pkg::Z_W-1:0]       point_z,
	output logic [dpb_pkg::COLOR_W-1:0]   point_blue,
	output logic [dpb_pkg::COLOR_W-1:0]   point_green,
	output logic [dpb_pkg::COLOR_W-1:0]   point_red,
	output logic                          has_point,
	output logic                          end_of_frame
);
	import dpb_pkg::*;

	// Frame position counters.
	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;
	logic [SIZE_W-1:0] width_eff;
	logic [SIZE_W-1:0] height_eff;
	logic              row_end;
	logic              frame_end;

	// Captured pixel.
	logic [NUM_W-1:0]   num_q;
	logic [POS_W-1:0]   pix_col_q;
	logic [POS_W-1:0]   pix_row_q;
	logic [COLOR_W-1:0] blue_q;
	logic [COLOR_W-1:0] green_q;
	logic [COLOR_W-1:0] red_q;
	logic               has_pt_q;
	logic               eof_q;

	// Arithmetic.
	logic [MUL_A_W-1:0]  mul_a;
	logic [MUL_B_W-1:0]  mul_b;
	logic [MUL_P_W-1:0]  mul_q;
	logic [Z_W-1:0]      z_q;
	logic [Z_W-1:0]      q_est;
	logic [RECIP_W-1:0]  rem;
	logic [Z_W-1:0]      z_next;
	logic [CENTER_W-1:0] pos16_x;
	logic [CENTER_W-1:0] pos16_y;
	logic                neg_x;
	logic                neg_y;
	logic [CENTER_W-1:0] mag_x;
	logic [CENTER_W-1:0] mag_y;
	logic [MUL_P_W-1:0]  rnd_sum;
	logic [COORD_W-2:0]  rnd_mag;
	logic [COORD_W-1:0]  coord_pos;
	logic [COORD_W-1:0]  coord_neg;
	logic [COORD_W-1:0]  x_q;
	logic [COORD_W-1:0]  y_q;
	logic                out_valid_q;

	always_comb begin
		if (cfg.frame_width == '0) begin
			width_eff = SIZE_W'(1);
		end else if (cfg.frame_width > MAX_WIDTH) begin
			width_eff = MAX_WIDTH;
		end else begin
			width_eff = cfg.frame_width;
		end
		if (cfg.frame_height == '0) begin
			height_eff = SIZE_W'(1);
		end else if (cfg.frame_height > MAX_HEIGHT) begin
			height_eff = MAX_HEIGHT;
		end else begin
			height_eff = cfg.frame_height;
		end
	end

	assign row_end   = ({1'b0, col_q} + SIZE_W'(1)) >= width_eff;
	assign frame_end = ({1'b0, row_q} + SIZE_W'(1)) >= height_eff;

	assign status.depth_zero = (depth_value == '0);
	assign status.last_pixel = row_end && frame_end;
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.capture) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + POS_W'(1);
			end else begin
				col_q <= col_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			num_q     <= {depth_value, 8'd0} + NUM_W'(DEPTH_DIVISOR / 2);
			pix_col_q <= col_q;
			pix_row_q <= row_q;
			blue_q    <= blue;
			green_q   <= green;
			red_q     <= red;
			has_pt_q  <= (depth_value != '0);
			eof_q     <= row_end && frame_end;
		end
	end

	// Signed distance from the principal point, as sign and magnitude, Q.4.
	assign pos16_x = {pix_col_q, 4'd0};
	assign pos16_y = {pix_row_q, 4'd0};
	assign neg_x   = pos16_x < cfg.center_x;
	assign neg_y   = pos16_y < cfg.center_y;
	assign mag_x   = neg_x ? cfg.center_x - pos16_x : pos16_x - cfg.center_x;
	assign mag_y   = neg_y ? cfg.center_y - pos16_y : pos16_y - cfg.center_y;

	always_comb begin
		case (cmd.mul_sel)
			MUL_Z: begin
				mul_a = MUL_A_W'(num_q);
				mul_b = RECIP_100;
			end
			MUL_MAGX: begin
				mul_a = MUL_A_W'(mag_x);
				mul_b = MUL_B_W'(z_q);
			end
			MUL_MAGY: begin
				mul_a = MUL_A_W'(mag_y);
				mul_b = MUL_B_W'(z_q);
			end
			MUL_INVX: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cfg.inv_focal_x);
			end
			MUL_INVY: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = MUL_B_W'(cfg.inv_focal_y);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			mul_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
		end
	end

	// The reciprocal estimate is exact or one short; one compare fixes it.
	assign q_est  = mul_q[RECIP_SHIFT +: Z_W];
	assign rem    = RECIP_W'(num_q) - RECIP_W'(q_est) * RECIP_W'(DEPTH_DIVISOR);
	assign z_next = q_est + Z_W'(rem >= RECIP_W'(DEPTH_DIVISOR));

	always_ff @(posedge clk) begin
		if (cmd.z_load) begin
			z_q <= z_next;
		end
	end

	// Round half away from zero on the magnitude. The magnitude, z and the
	// reciprocal bound the result below 2^30, so it never needs saturation.
	assign rnd_sum   = mul_q + (MUL_P_W'(1) << (FRAC_SHIFT - 1));
	assign rnd_mag   = rnd_sum[FRAC_SHIFT +: COORD_W - 1];
	assign coord_pos = {1'b0, rnd_mag};
	assign coord_neg = COORD_W'(0) - coord_pos;

	always_ff @(posedge clk) begin
		if (cmd.x_load) begin
			x_q <= neg_x ? coord_neg : coord_pos;
		end
		if (cmd.y_load) begin
			y_q <= neg_y ? coord_neg : coord_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (has_pt_q) begin
				point_x     <= x_q;
				point_y     <= y_q;
				point_z     <= z_q;
				point_blue  <= blue_q;
				point_green <= green_q;
				point_red   <= red_q;
			end else begin
				point_x     <= '0;
				point_y     <= '0;
				point_z     <= '0;
				point_blue  <= '0;
				point_green <= '0;
				point_red   <= '0;
			end
			has_point    <= has_pt_q;
			end_of_frame <= eof_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/depth_pixel_backprojection_top.sv
// Channel  Handshake               Word
// -------  ----------------------  -----------------------------------------------
// in       in_valid / in_ready     depth_value, blue, green, red
// out      out_valid / out_ready   point_x, point_y, point_z, point_blue,
//                                  point_green, point_red, has_point, end_of_frame
// cfg      cfg_write               cfg_index, cfg_data
//
// A pixel with nonzero depth is finished in full before the block is
// ready again: one shared multiplier is used five times (z reciprocal, then for
// x and for y the magnitude times z and that product times the reciprocal focal
// length) plus correction, rounding and output load steps. A zero-depth pixel
// skips them, and only the last pixel of a frame then goes on to the output load.
// Reset (arst_n low) clears the frame position, the state machine, the output
// valid flag and restores the default camera configuration.
// The output register holds a finished word while out_ready is low; the next
// pixel is accepted meanwhile, and the block waits only when a second result is
// ready before the first has been taken.
module depth_pixel_backprojection_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dpb_pkg::DEPTH_W-1:0]       depth_value,
	input  logic [dpb_pkg::COLOR_W-1:0]       blue,
	input  logic [dpb_pkg::COLOR_W-1:0]       green,
	input  logic [dpb_pkg::COLOR_W-1:0]       red,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [dpb_pkg::COORD_W-1:0] point_x,
	output logic signed [dpb_pkg::COORD_W-1:0] point_y,
	output logic [dpb_pkg::Z_W-1:0]           point_z,
	output logic [dpb_pkg::COLOR_W-1:0]       point_blue,
	output logic [dpb_pkg::COLOR_W-1:0]       point_green,
	output logic [dpb_pkg::COLOR_W-1:0]       point_red,
	output logic                              has_point,
	output logic                              end_of_frame,
	input  logic                              cfg_write,
	input  logic [dpb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dpb_pkg::CFG_DAT_W-1:0]     cfg_data
);
	import dpb_pkg::*;

	dpb_cfg_t    cfg_q;
	dpb_cmd_t    cmd;
	dpb_status_t status;

	// Camera configuration registers. The defaults describe a 640 by 480
	// sensor with its principal point at the frame center. The user must write
	// only while the block is idle, so no shadowing is needed; the block itself
	// does not enforce this. Unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width  <= SIZE_W'(640);
			cfg_q.frame_height <= SIZE_W'(480);
			cfg_q.center_x     <= CENTER_W'(5120);
			cfg_q.center_y     <= CENTER_W'(3840);
			cfg_q.inv_focal_x  <= INV_W'(27962);
			cfg_q.inv_focal_y  <= INV_W'(27962);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data[SIZE_W-1:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data[SIZE_W-1:0];
				REG_CENTER_X:     cfg_q.center_x     <= cfg_data[CENTER_W-1:0];
				REG_CENTER_Y:     cfg_q.center_y     <= cfg_data[CENTER_W-1:0];
				REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= cfg_data[INV_W-1:0];
				REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= cfg_data[INV_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The controller sequences the shared multiplier and decides, from the
	// depth and the frame position, whether a pixel yields a word at all.
	dpb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the frame counters, the captured pixel, the
	// multiplier, the rounding logic and the output register.
	dpb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.depth_value  (depth_value),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.point_blue   (point_blue),
		.point_green  (point_green),
		.point_red    (point_red),
		.has_point    (has_point),
		.end_of_frame (end_of_frame)
	);

endmodule

>>> sim/tb_depth_pixel_backprojection_top.sv
module tb_depth_pixel_backprojection_top;
	timeunit 1ns;
	timeprecision 1ps;

	import dpb_pkg::*;

	// A run with no word moving on either channel for this many cycles is hung.
	localparam int WATCHDOG_LIMIT = 2000;
	// Settle time before touching registers, longer than any pixel needs.
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_PIXELS = 80;
	// Pixels sent along the first row and down the first column of the largest frames.
	localparam int EDGE_PIXELS = 200;
	localparam longint unsigned Z_LIMIT = (64'd1 << Z_W) - 1;

	// Indexes beyond the last register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = CFG_IDX_W'(7);

	// One output word as the block should present it.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [Z_W-1:0]     z;
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
		logic               has_point;
		logic               end_of_frame;
	} point_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_ready;
	logic [DEPTH_W-1:0]         depth_value;
	logic [COLOR_W-1:0]         blue;
	logic [COLOR_W-1:0]         green;
	logic [COLOR_W-1:0]         red;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [COORD_W-1:0]  point_x;
	logic signed [COORD_W-1:0]  point_y;
	logic [Z_W-1:0]             point_z;
	logic [COLOR_W-1:0]         point_blue;
	logic [COLOR_W-1:0]         point_green;
	logic [COLOR_W-1:0]         point_red;
	logic                       has_point;
	logic                       end_of_frame;
	logic                       cfg_write;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DAT_W-1:0]       cfg_data;

	// Camera settings and frame position as the block should hold them.
	logic [SIZE_W-1:0]   width_setting;
	logic [SIZE_W-1:0]   height_setting;
	logic [CENTER_W-1:0] center_x_setting;
	logic [CENTER_W-1:0] center_y_setting;
	logic [INV_W-1:0]    inv_focal_x_setting;
	logic [INV_W-1:0]    inv_focal_y_setting;
	int unsigned         column_pos;
	int unsigned         row_pos;

	// Points predicted for accepted pixels, oldest first.
	point_t pending_points[$];
	point_t arriving_point;

	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;

	depth_pixel_backprojection_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.depth_value  (depth_value),
		.blue         (blue),
		.green        (green),
		.red          (red),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.point_blue   (point_blue),
		.point_green  (point_green),
		.point_red    (point_red),
		.has_point    (has_point),
		.end_of_frame (end_of_frame),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// A frame size of zero behaves as one, anything above the maximum as the maximum.
	function automatic int unsigned clamp_size(input logic [SIZE_W-1:0] size,
			input logic [SIZE_W-1:0] limit);
		if (size == '0) begin
			return 1;
		end
		if (size > limit) begin
			return 32'(limit);
		end
		return 32'(size);
	endfunction

	// Offset from the principal point (Q.4) times z (Q.8) times the reciprocal
	// focal length (Q0.24) gives Q.36; drop 28 bits rounding away from zero, then
	// saturate to the signed 32-bit range.
	function automatic logic [COORD_W-1:0] project_axis(input int unsigned pos,
			input logic [CENTER_W-1:0] center, input logic [Z_W-1:0] z,
			input logic [INV_W-1:0] inv);
		longint unsigned scaled_pos;
		longint unsigned offset;
		longint unsigned product;
		longint unsigned rounded;
		bit              negative;
		scaled_pos = 64'(pos) * 64'd16;
		negative = scaled_pos < 64'(center);
		offset = negative ? 64'(center) - scaled_pos : scaled_pos - 64'(center);
		product = offset * 64'(z) * 64'(inv);
		rounded = (product + (64'd1 << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
		if (negative) begin
			if (rounded > 64'h8000_0000) begin
				rounded = 64'h8000_0000;
			end
			return COORD_W'(64'd0 - rounded);
		end
		if (rounded > 64'h7FFF_FFFF) begin
			rounded = 64'h7FFF_FFFF;
		end
		return COORD_W'(rounded);
	endfunction

	// Appends one predicted point behind the ones already waiting.
	function automatic void queue_point(input point_t p);
		pending_points = {pending_points, p};
	endfunction

	// Advances the frame position for one pixel and queues the point it yields, if any.
	function automatic void project_pixel(input logic [DEPTH_W-1:0] depth,
			input logic [COLOR_W-1:0] b, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] r);
		int unsigned     frame_w;
		int unsigned     frame_h;
		int unsigned     col;
		int unsigned     row;
		bit              row_end;
		bit              last_pixel;
		longint unsigned z_full;
		point_t          p;
		frame_w = clamp_size(width_setting, MAX_WIDTH);
		frame_h = clamp_size(height_setting, MAX_HEIGHT);
		col = column_pos;
		row = row_pos;
		// A counter already past the frame edge (size lowered mid-frame) wraps too.
		row_end = (col + 1 >= frame_w);
		last_pixel = row_end && (row + 1 >= frame_h);
		if (row_end) begin
			column_pos = 0;
			row_pos = last_pixel ? 0 : row + 1;
		end else begin
			column_pos = col + 1;
		end
		p = '0;
		if (depth != '0) begin
			z_full = (64'(depth) * 64'd256 + 64'(DEPTH_DIVISOR / 2)) / 64'(DEPTH_DIVISOR);
			if (z_full > Z_LIMIT) begin
				z_full = Z_LIMIT;
			end
			p.z = Z_W'(z_full);
			p.x = project_axis(col, center_x_setting, p.z, inv_focal_x_setting);
			p.y = project_axis(row, center_y_setting, p.z, inv_focal_y_setting);
			p.blue = b;
			p.green = g;
			p.red = r;
			p.has_point = 1'b1;
			p.end_of_frame = last_pixel;
			queue_point(p);
		end else if (last_pixel) begin
			// An empty last pixel still closes the frame, with every other field zero.
			p.end_of_frame = 1'b1;
			queue_point(p);
		end
	endfunction

	function automatic void check_field(input string name, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Random bits above the register width; the block must drop them.
	function automatic logic [CFG_DAT_W-1:0] with_noise(input logic [CFG_DAT_W-1:0] value,
			input int bits);
		return (CFG_DAT_W'($urandom) << bits) | value;
	endfunction

	// The receiver stalls at random, at the rate the current phase asks for.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= receiver_stall_pct);
	end

	// Every word taken from the block is compared with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				$display("%0t: unexpected word, expected none actual x %0h y %0h z %0h eof %0b",
					$time, point_x, point_y, point_z, end_of_frame);
				mismatches++;
			end else begin
				arriving_point = pending_points.pop_front();
				check_field("point_x", arriving_point.x, point_x);
				check_field("point_y", arriving_point.y, point_y);
				check_field("point_z", COORD_W'(arriving_point.z), COORD_W'(point_z));
				check_field("point_blue", COORD_W'(arriving_point.blue),
					COORD_W'(point_blue));
				check_field("point_green", COORD_W'(arriving_point.green),
					COORD_W'(point_green));
				check_field("point_red", COORD_W'(arriving_point.red), COORD_W'(point_red));
				check_field("has_point", COORD_W'(arriving_point.has_point),
					COORD_W'(has_point));
				check_field("end_of_frame", COORD_W'(arriving_point.end_of_frame),
					COORD_W'(end_of_frame));
			end
		end
	end

	// Watchdog: ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// Offers one pixel, after a random gap, and holds it until the block takes it.
	// Returns at the next falling edge with valid still high; the caller either
	// sends again or settles the block, which lowers it.
	task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] b,
			input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] r);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		depth_value = depth;
		blue = b;
		green = g;
		red = r;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		project_pixel(depth, b, g, r);
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted word has come out and the
	// block has had time to finish any pixel that yields nothing.
	task automatic settle_block;
		in_valid = 1'b0;
		while (pending_points.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Called at a falling edge with the block idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_FRAME_WIDTH: begin
				width_setting = data[SIZE_W-1:0];
			end
			REG_FRAME_HEIGHT: begin
				height_setting = data[SIZE_W-1:0];
			end
			REG_CENTER_X: begin
				center_x_setting = data[CENTER_W-1:0];
			end
			REG_CENTER_Y: begin
				center_y_setting = data[CENTER_W-1:0];
			end
			REG_INV_FOCAL_X: begin
				inv_focal_x_setting = data[INV_W-1:0];
			end
			REG_INV_FOCAL_Y: begin
				inv_focal_y_setting = data[INV_W-1:0];
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic program_camera(input logic [CFG_DAT_W-1:0] frame_w,
			input logic [CFG_DAT_W-1:0] frame_h, input logic [CFG_DAT_W-1:0] cx,
			input logic [CFG_DAT_W-1:0] cy, input logic [CFG_DAT_W-1:0] fx,
			input logic [CFG_DAT_W-1:0] fy);
		write_register(REG_FRAME_WIDTH, frame_w);
		write_register(REG_FRAME_HEIGHT, frame_h);
		write_register(REG_CENTER_X, cx);
		write_register(REG_CENTER_Y, cy);
		write_register(REG_INV_FOCAL_X, fx);
		write_register(REG_INV_FOCAL_Y, fy);
	endtask

	// Default camera right after reset: depth extremes, rounding of z and color
	// extremes, all in the first row of a 640 by 480 frame.
	task automatic test_default_camera;
		send_pixel(16'd1, 8'h00, 8'h00, 8'h00);
		send_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
		send_pixel(16'd0, 8'h5A, 8'hA5, 8'h3C);
		send_pixel(16'd100, 8'h01, 8'h80, 8'hFE);
		send_pixel(16'd50, 8'hAA, 8'h55, 8'h0F);
		send_pixel(16'd13, 8'hF0, 8'h0F, 8'h99);
		settle_block();
	endtask

	// The frame shrinks to 4 by 2 while the column counter sits at 6, past the
	// new edge: the next pixel must wrap. Spare register indexes are written too
	// and must have no effect. One frame ends on an empty pixel, the next on a
	// pixel with depth.
	task automatic test_frame_shrink;
		logic [DEPTH_W-1:0] depth;
		write_register(REG_SPARE_LOW, CFG_DAT_W'($urandom));
		program_camera(24'd4, 24'd2, 24'd32, 24'd8, 24'd400000, 24'd300000);
		write_register(REG_SPARE_HIGH, CFG_DAT_W'($urandom));
		for (int i = 0; i < 13; i++) begin
			depth = (i == 4 || i % 3 == 1) ? 16'd0 : DEPTH_W'(1000 * i + 7);
			send_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
		end
		settle_block();
	endtask

	// Principal point and reciprocal focal length at both ends of their range,
	// including a zero reciprocal, which must give zero coordinates.
	task automatic test_camera_extremes;
		program_camera(24'd2, 24'd1, 24'd0, 24'hFFFF, 24'hFFFFFF, 24'd1);
		send_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56);
		send_pixel(16'hFFFF, 8'h78, 8'h9A, 8'hBC);
		settle_block();
		program_camera(24'd2, 24'd1, 24'hFFFF, 24'd0, 24'd0, 24'd0);
		send_pixel(16'hFFFF, 8'hDE, 8'hF0, 8'h11);
		send_pixel(16'd1, 8'h22, 8'h33, 8'h44);
		settle_block();
	endtask

	// A zero width and height act as one, so every pixel ends a frame.
	task automatic test_size_clamps;
		program_camera(24'd0, 24'd0, 24'd0, 24'd0, 24'd27962, 24'd27962);
		send_pixel(16'd0, 8'hFF, 8'h00, 8'hFF);
		send_pixel(16'd7, 8'h00, 8'hFF, 8'h00);
		send_pixel(16'hFFFF, 8'hC3, 8'h3C, 8'h81);
		settle_block();
	endtask

	// Widest and tallest frames, the width reached through a register value above
	// the maximum and bits above the register width, the height written at the
	// maximum. A run of pixels along the first row and then down the first column
	// shows that neither counter wraps early. Most pixels are empty.
	task automatic test_widest_frames;
		logic [DEPTH_W-1:0] depth;
		sender_idle_pct = 16;
		receiver_stall_pct = 16;
		program_camera(24'hFFFFFF, 24'hFFE000, 24'd32760, 24'd0, 24'd16384, 24'd16384);
		for (int i = 0; i < EDGE_PIXELS; i++) begin
			depth = ($urandom_range(63) == 0 || i == EDGE_PIXELS - 1)
				? DEPTH_W'($urandom_range(1, 65535)) : 16'd0;
			send_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
		end
		settle_block();
		program_camera(24'h002000, 24'h001000, 24'd0, 24'd32760, 24'd16384, 24'd16384);
		for (int i = 0; i < EDGE_PIXELS; i++) begin
			depth = ($urandom_range(63) == 0 && i != EDGE_PIXELS - 1)
				? DEPTH_W'($urandom_range(1, 65535)) : 16'd0;
			send_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
		end
		settle_block();
	endtask

	// Picks a fresh camera, mostly small frames so that frame ends come often.
	task automatic program_random_camera;
		logic [SIZE_W-1:0]   frame_w;
		logic [SIZE_W-1:0]   frame_h;
		logic [CENTER_W-1:0] cx;
		logic [CENTER_W-1:0] cy;
		logic [INV_W-1:0]    fx;
		logic [INV_W-1:0]    fy;
		case ($urandom_range(9))
			0: frame_w = '0;
			1: frame_w = SIZE_W'($urandom);
			2: frame_w = SIZE_W'($urandom_range(9, 64));
			default: frame_w = SIZE_W'($urandom_range(1, 8));
		endcase
		case ($urandom_range(9))
			0: frame_h = '0;
			1: frame_h = SIZE_W'($urandom);
			2: frame_h = SIZE_W'($urandom_range(7, 32));
			default: frame_h = SIZE_W'($urandom_range(1, 6));
		endcase
		for (int axis = 0; axis < 2; axis++) begin
			case ($urandom_range(3))
				0: cy = '0;
				1: cy = '1;
				default: cy = CENTER_W'($urandom);
			endcase
			case ($urandom_range(5))
				0: fy = '0;
				1: fy = '1;
				2: fy = INV_W'(1);
				3: fy = INV_W'($urandom);
				default: fy = INV_W'($urandom_range(20000, 60000));
			endcase
			if (axis == 0) begin
				cx = cy;
				fx = fy;
			end
		end
		program_camera(with_noise(CFG_DAT_W'(frame_w), SIZE_W),
			with_noise(CFG_DAT_W'(frame_h), SIZE_W),
			with_noise(CFG_DAT_W'(cx), CENTER_W), with_noise(CFG_DAT_W'(cy), CENTER_W),
			fx, fy);
		if ($urandom_range(1) == 0) begin
			write_register($urandom_range(1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
				CFG_DAT_W'($urandom));
		end
	endtask

	// Random pixels under a new camera per phase, cycling through the idling
	// patterns: none, sender gaps, receiver stalls, and both at a lower rate.
	task automatic test_random_frames;
		logic [DEPTH_W-1:0] depth;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_block();
			case (phase % 4)
				0: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 57;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					receiver_stall_pct = 57;
				end
				default: begin
					sender_idle_pct = 16;
					receiver_stall_pct = 16;
				end
			endcase
			program_random_camera();
			for (int i = 0; i < PHASE_PIXELS; i++) begin
				case ($urandom_range(9))
					0, 1: depth = '0;
					2: depth = $urandom_range(1) ? '1 : DEPTH_W'(1);
					3: depth = DEPTH_W'($urandom_range(1, 255));
					default: depth = DEPTH_W'($urandom);
				endcase
				send_pixel(depth, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
			end
		end
		settle_block();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		depth_value = '0;
		blue = '0;
		green = '0;
		red = '0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		// Reset values of the camera registers and the frame position.
		width_setting = SIZE_W'(640);
		height_setting = SIZE_W'(480);
		center_x_setting = CENTER_W'(5120);
		center_y_setting = CENTER_W'(3840);
		inv_focal_x_setting = INV_W'(27962);
		inv_focal_y_setting = INV_W'(27962);
		column_pos = 0;
		row_pos = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_camera();
		test_frame_shrink();
		test_camera_extremes();
		test_size_clamps();
		test_widest_frames();
		test_random_frames();

		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
